FILE: design/hsl_pkg.sv
// shared types and constants for the rgb to hsl converter
package hsl_pkg;

    localparam int CW        = 16;          // component and result width
    localparam int HDW       = CW + 3;      // hue divisor width, holds 6*delta
    localparam int QSTEPS    = CW;          // quotient bits, one per divider stage
    localparam logic [CW:0] CODE_ONE  = 17'd65535;
    localparam logic [CW:0] CODE_TWO  = 17'd131070;

    // which component holds the maximum
    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } max_sel_t;

    // payload carried through the divider stages
    typedef struct packed {
        logic [CW-1:0]  sat_rem;
        logic [CW-1:0]  sat_low;
        logic [CW-1:0]  sat_div;
        logic [CW-1:0]  sat_q;
        logic [HDW-1:0] hue_rem;
        logic [HDW-1:0] hue_div;
        logic [CW-1:0]  hue_q;
        logic           grey;
        logic [CW-1:0]  light;
    } div_word_t;

endpackage

FILE: design/rgb_to_hsl_converter_top.sv
// top level of the rgb to hsl converter
//
// Converts one pixel per beat from 16-bit red, green, blue codes to hue,
// saturation and lightness. Input beats arrive on s_valid/s_ready with
// s_red_in, s_green_in, s_blue_in; results leave on m_valid/m_ready with
// m_hue_out, m_sat_out, m_light_out, one result beat per input beat, in order.
// There are 19 register stages: two front stages (max/min, then delta and
// divisor setup), sixteen divider stages that each resolve one quotient bit
// of saturation and hue, and the output register. m_valid rises when a beat
// has passed both front stages and all divider stages into the output register.
// Throughput is one pixel per cycle while m_ready stays high.
// The whole pipeline advances together: when a result sits in the output
// register and m_ready is low, s_ready drops and every stage holds its beat,
// so nothing is lost or repeated. A stall costs exactly its own cycles.
// Synchronous active-low reset clears all valid bits; no result is pending
// after reset and the block accepts a beat in the first cycle after it.
module rgb_to_hsl_converter_top (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [hsl_pkg::CW-1:0]  s_red_in,
    input  logic [hsl_pkg::CW-1:0]  s_green_in,
    input  logic [hsl_pkg::CW-1:0]  s_blue_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [hsl_pkg::CW-1:0]  m_hue_out,
    output logic [hsl_pkg::CW-1:0]  m_sat_out,
    output logic [hsl_pkg::CW-1:0]  m_light_out
);
    import hsl_pkg::*;

    logic       en;
    logic       p_valid, d_valid;
    div_word_t  p_word, d_word;
    logic       m_valid_reg, grey_reg;
    logic [CW-1:0] hue_reg, sat_reg, light_reg;

    // global advance
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    hsl_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .red       (s_red_in),
        .green     (s_green_in),
        .blue      (s_blue_in),
        .out_valid (p_valid),
        .out_word  (p_word)
    );

    hsl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p_valid),
        .in_word   (p_word),
        .out_valid (d_valid),
        .out_word  (d_word)
    );

    // output register, grey pixels force hue and saturation to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg   <= d_word.grey ? '0 : d_word.hue_q;
            sat_reg   <= d_word.grey ? '0 : d_word.sat_q;
            light_reg <= d_word.light;
            grey_reg  <= d_word.grey;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hue_out   = hue_reg;
    assign m_sat_out   = sat_reg;
    assign m_light_out = light_reg;

    // checks
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("s_ready low with empty output register");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid after reset");

    a_grey_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && grey_reg |-> hue_reg == '0 && sat_reg == '0)
        else $error("grey pixel with nonzero hue or saturation");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(hue_reg)
            && $stable(sat_reg) && $stable(light_reg))
        else $error("result changed during stall");

endmodule

FILE: design/hsl_prep.sv
// front stages: max/min select, then delta, lightness, numerators and divisors
module hsl_prep (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [hsl_pkg::CW-1:0]     red,
    input  logic [hsl_pkg::CW-1:0]     green,
    input  logic [hsl_pkg::CW-1:0]     blue,
    output logic                       out_valid,
    output hsl_pkg::div_word_t         out_word
);
    import hsl_pkg::*;

    logic              v1_reg, v2_reg;
    logic [CW-1:0]     r1_reg, g1_reg, b1_reg, mx1_reg, mn1_reg;
    max_sel_t          sel1_reg;
    max_sel_t          sel_next;
    logic [CW-1:0]     mx_next, mn_next;
    div_word_t         w2_reg, w2_next;

    // stage 1: pick maximum (red wins ties, then green) and minimum
    always_comb begin
        if (red >= green && red >= blue) begin
            sel_next = SEL_RED;
            mx_next  = red;
        end else if (green >= blue) begin
            sel_next = SEL_GREEN;
            mx_next  = green;
        end else begin
            sel_next = SEL_BLUE;
            mx_next  = blue;
        end
        mn_next = red;
        if (green < mn_next) mn_next = green;
        if (blue < mn_next) mn_next = blue;
    end

    // stage 2: delta, sum, hue numerator with wrap, divisors
    logic [CW-1:0]        d;
    logic [CW:0]          s;
    logic signed [HDW:0]  n_raw, n_adj;
    logic [HDW-1:0]       d6;
    logic [2*CW-1:0]      sat_num;
    always_comb begin
        d  = mx1_reg - mn1_reg;
        s  = {1'b0, mx1_reg} + {1'b0, mn1_reg};
        d6 = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
        case (sel1_reg)
            SEL_RED:   n_raw = $signed({4'b0, g1_reg}) - $signed({4'b0, b1_reg});
            SEL_GREEN: n_raw = $signed({3'b0, d, 1'b0}) + $signed({4'b0, b1_reg})
                             - $signed({4'b0, r1_reg});
            default:   n_raw = $signed({2'b0, d, 2'b0}) + $signed({4'b0, r1_reg})
                             - $signed({4'b0, g1_reg});
        endcase
        n_adj = n_raw[HDW] ? n_raw + $signed({1'b0, d6}) : n_raw;
        sat_num = {d, {CW{1'b0}}} - {{CW{1'b0}}, d};
        w2_next.sat_rem = sat_num[2*CW-1:CW];
        w2_next.sat_low = sat_num[CW-1:0];
        if (s < CODE_ONE) w2_next.sat_div = s[CW-1:0];
        else begin
            w2_next.sat_div = 16'(CODE_TWO - s);
        end
        w2_next.sat_q   = '0;
        w2_next.hue_rem = n_adj[HDW-1:0];
        w2_next.hue_div = d6;
        w2_next.hue_q   = '0;
        w2_next.grey    = (d == '0);
        w2_next.light   = s[CW:1];
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg   <= red;
            g1_reg   <= green;
            b1_reg   <= blue;
            mx1_reg  <= mx_next;
            mn1_reg  <= mn_next;
            sel1_reg <= sel_next;
            w2_reg   <= w2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_word  = w2_reg;

endmodule

FILE: design/hsl_div.sv
// two restoring dividers side by side, one quotient bit per stage
module hsl_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  hsl_pkg::div_word_t   in_word,
    output logic                 out_valid,
    output hsl_pkg::div_word_t   out_word
);
    import hsl_pkg::*;

    logic      v_reg [QSTEPS];
    div_word_t w_reg [QSTEPS];

    function automatic div_word_t div_step(input div_word_t w);
        div_word_t       o;
        logic [CW:0]     st;
        logic [HDW:0]    ht;
        logic            sge, hge;
        o   = w;
        st  = {w.sat_rem, w.sat_low[CW-1]};
        sge = st >= {1'b0, w.sat_div};
        st  = sge ? st - {1'b0, w.sat_div} : st;
        o.sat_rem = st[CW-1:0];
        o.sat_low = {w.sat_low[CW-2:0], 1'b0};
        o.sat_q   = {w.sat_q[CW-2:0], sge};
        ht  = {w.hue_rem, 1'b0};
        hge = ht >= {1'b0, w.hue_div};
        ht  = hge ? ht - {1'b0, w.hue_div} : ht;
        o.hue_rem = ht[HDW-1:0];
        o.hue_q   = {w.hue_q[CW-2:0], hge};
        return o;
    endfunction

    // stage chain
    for (genvar k = 0; k < QSTEPS; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                w_reg[k] <= div_step((k == 0) ? in_word : w_reg[(k == 0) ? 0 : k-1]);
            end
        end
    end

    assign out_valid = v_reg[QSTEPS-1];
    assign out_word  = w_reg[QSTEPS-1];

endmodule
